/* sv/rbe_pkg.sv */
// rbe_pkg: shared types and constants of the byte-wise rANS encoder.
// Used by rbe_table, rbe_divider and rans_byte_encoder_unit; no dependencies.
package rbe_pkg;

    localparam int SCALE_BITS_DEF  = 12;
    localparam int NUM_SYMBOLS_DEF = 256;

    localparam int OP_W    = 2;
    localparam int SYM_W   = 8;
    localparam int FREQ_W  = 13;
    localparam int CUM_W   = 12;
    localparam int BYTE_W  = 8;
    localparam int STATE_W = 33;

    localparam logic [STATE_W-1:0] STATE_INIT = {1'b1, {(STATE_W-1){1'b0}}};

    // at most this many bytes leave the coder for one request
    localparam int MAX_BYTES = 5;
    localparam int COUNT_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_ERROR,
        ST_RENORM,
        ST_DIV,
        ST_FLUSH
    } state_t;

    // table port: one write (load) or one read (encode) per cycle
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [SYM_W-1:0]  symbol;
        logic [FREQ_W-1:0] freq;
        logic [CUM_W-1:0]  cum;
    } tbl_req_t;

endpackage

/* sv/rbe_table.sv */
// rbe_table: symbol table memory (frequency and cumulative start).
// Synchronous read, data valid in the cycle after the request; valid bits give the all-zero reset.
// Depends on rbe_pkg.
module rbe_table #(
    parameter int NUM_SYMBOLS = rbe_pkg::NUM_SYMBOLS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rbe_pkg::tbl_req_t            req,
    output logic [rbe_pkg::FREQ_W-1:0]   rd_freq,
    output logic [rbe_pkg::CUM_W-1:0]    rd_cum
);

    localparam int ADDR_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int WORD_W = rbe_pkg::FREQ_W + rbe_pkg::CUM_W;

    logic [WORD_W-1:0]      mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] valid_reg;
    logic [WORD_W-1:0]      rd_word_reg;
    logic                   rd_hit_reg;
    logic                   rd_hit_next;
    logic                   in_range;
    logic [ADDR_W-1:0]      addr;

    assign in_range = {1'b0, req.symbol} < (rbe_pkg::SYM_W + 1)'(NUM_SYMBOLS);
    assign addr     = req.symbol[ADDR_W-1:0];

    always_comb
    begin
        rd_hit_next = rd_hit_reg;
        if (req.rd_en)
        begin
            rd_hit_next = in_range && valid_reg[addr];
        end
    end

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (req.wr_en && in_range)
        begin
            mem[addr] <= {req.freq, req.cum};
        end
        if (req.rd_en && in_range)
        begin
            rd_word_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            rd_hit_reg <= rd_hit_next;
            if (req.wr_en && in_range)
            begin
                valid_reg[addr] <= 1'b1;
            end
        end
    end

    // an entry never loaded (or out of range) reads as zero
    assign rd_freq = rd_hit_reg ? rd_word_reg[WORD_W-1 -: rbe_pkg::FREQ_W] : '0;
    assign rd_cum  = rd_hit_reg ? rd_word_reg[rbe_pkg::CUM_W-1:0] : '0;

endmodule

/* sv/rbe_divider.sv */
// rbe_divider: restoring divider, one quotient bit per cycle.
// Divisor must be non-zero. Depends on rbe_pkg for default widths.
module rbe_divider #(
    parameter int DIVIDEND_W = rbe_pkg::STATE_W,
    parameter int DIVISOR_W  = rbe_pkg::FREQ_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    logic [CNT_W-1:0]      cnt_reg,   cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg,   quo_next;
    logic [DIVISOR_W-1:0]  rem_reg,   rem_next;
    logic [DIVISOR_W-1:0]  div_reg,   div_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  q_bit;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign q_bit = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], q_bit};
            rem_next = q_bit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* sv/rans_byte_encoder_unit.sv */
// rans_byte_encoder_unit: top level of the byte-wise rANS encoder core.
// Depends on rbe_pkg, rbe_table and rbe_divider.
//
// Byte-wise rANS encoder with a probability scale of 2^SCALE_BITS. A load
// request (tuser = 0) writes one symbol's frequency and cumulative start into
// the symbol table; the table reads as all zeros after reset,
// without any clearing pass. Encode requests (tuser = 1) must come in
// reverse symbol order. Each encode first pushes the low state byte while
// state >= freq << (32 - SCALE_BITS), then runs the state update
// state = (state / freq) << SCALE_BITS + state mod freq + cum. The output
// side can stall each pushed byte (0 to 2 of them at the default scale),
// and the update waits for the bit-serial divider. A symbol with zero
// frequency yields one result with the error flag and leaves the state
// untouched. A flush request (tuser = 2) pushes state bytes, flagged
// block_end, until the state is zero (up to five bytes), then restores the
// initial state 2^32. Request code 3 is ignored. One request is worked on
// at a time; a finished byte waits in the output register while the next
// request enters.
module rans_byte_encoder_unit #(
    parameter int SCALE_BITS  = rbe_pkg::SCALE_BITS_DEF,
    parameter int NUM_SYMBOLS = rbe_pkg::NUM_SYMBOLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] symbol, [20:8] frequency, [32:21] cum_start, zero pad
    input  logic [1:0]  s_tuser,   // [1:0] operation
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // last
    output logic [1:0]  m_tuser    // [0] block_end, [1] error
);

    localparam int STATE_W = rbe_pkg::STATE_W;
    localparam int SHIFT   = 32 - SCALE_BITS;
    localparam int LIMIT_W = rbe_pkg::FREQ_W + SHIFT;
    localparam int CMP_W   = (LIMIT_W > STATE_W) ? LIMIT_W : STATE_W;

    // request fields
    rbe_pkg::op_t                 in_op;
    logic [rbe_pkg::SYM_W-1:0]    in_symbol;
    logic [rbe_pkg::FREQ_W-1:0]   in_freq;
    logic [rbe_pkg::CUM_W-1:0]    in_cum;
    logic                         in_fire;

    rbe_pkg::state_t              state_reg, state_next;
    logic [STATE_W-1:0]           coder_reg, coder_next;
    logic [rbe_pkg::COUNT_W-1:0]  count_reg, count_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic [rbe_pkg::BYTE_W-1:0]   out_byte_reg,  out_byte_next;
    logic                         out_last_reg,  out_last_next;
    logic                         out_blk_reg,   out_blk_next;
    logic                         out_err_reg,   out_err_next;

    // table and divider
    rbe_pkg::tbl_req_t            tbl_req;
    logic [rbe_pkg::FREQ_W-1:0]   tbl_freq;
    logic [rbe_pkg::CUM_W-1:0]    tbl_cum;
    logic                         div_start;
    logic                         div_done;
    logic [STATE_W-1:0]           div_quo;
    logic [rbe_pkg::FREQ_W-1:0]   div_rem;

    // control
    logic                         slot_free;
    logic                         emit;
    logic                         renorm_more;
    logic                         renorm_last;
    logic                         flush_more;
    logic                         flush_last;
    logic                         count_full;
    logic [STATE_W-1:0]           coder_shr;
    logic [CMP_W-1:0]             limit;
    logic [STATE_W-1:0]           coder_upd;

    assign in_op     = rbe_pkg::op_t'(s_tuser);
    assign in_symbol = s_tdata[7:0];
    assign in_freq   = s_tdata[20:8];
    assign in_cum    = s_tdata[32:21];

    assign s_tready = (state_reg == rbe_pkg::ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    assign tbl_req.wr_en  = in_fire && (in_op == rbe_pkg::OP_LOAD);
    assign tbl_req.rd_en  = in_fire && (in_op == rbe_pkg::OP_ENCODE);
    assign tbl_req.symbol = in_symbol;
    assign tbl_req.freq   = in_freq;
    assign tbl_req.cum    = in_cum;

    rbe_table #(
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .rd_freq (tbl_freq),
        .rd_cum  (tbl_cum)
    );

    rbe_divider #(
        .DIVIDEND_W (STATE_W),
        .DIVISOR_W  (rbe_pkg::FREQ_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (coder_reg),
        .divisor   (tbl_freq),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // renormalisation bound and per-byte decisions
    assign limit       = CMP_W'(tbl_freq) << SHIFT;
    assign coder_shr   = coder_reg >> rbe_pkg::BYTE_W;
    assign count_full  = (count_reg == rbe_pkg::COUNT_W'(rbe_pkg::MAX_BYTES));
    assign renorm_more = (CMP_W'(coder_reg) >= limit) && !count_full;
    assign renorm_last = (CMP_W'(coder_shr) < limit)
                         || (count_reg == rbe_pkg::COUNT_W'(rbe_pkg::MAX_BYTES - 1));
    assign flush_more  = (coder_reg != '0) && !count_full;
    assign flush_last  = (coder_shr == '0)
                         || (count_reg == rbe_pkg::COUNT_W'(rbe_pkg::MAX_BYTES - 1));
    assign slot_free   = !out_valid_reg || m_tready;

    // state update, wraps modulo 2^33
    assign coder_upd = (div_quo << SCALE_BITS) + STATE_W'(div_rem) + STATE_W'(tbl_cum);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rbe_pkg::ST_IDLE:
            begin
                if (in_fire && (in_op == rbe_pkg::OP_ENCODE))
                begin
                    state_next = rbe_pkg::ST_LOOKUP;
                end
                else if (in_fire && (in_op == rbe_pkg::OP_FLUSH))
                begin
                    state_next = rbe_pkg::ST_FLUSH;
                end
            end
            rbe_pkg::ST_LOOKUP:
            begin
                state_next = (tbl_freq == '0) ? rbe_pkg::ST_ERROR : rbe_pkg::ST_RENORM;
            end
            rbe_pkg::ST_ERROR:
            begin
                if (slot_free)
                begin
                    state_next = rbe_pkg::ST_IDLE;
                end
            end
            rbe_pkg::ST_RENORM:
            begin
                if (!renorm_more)
                begin
                    state_next = rbe_pkg::ST_DIV;
                end
            end
            rbe_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = rbe_pkg::ST_IDLE;
                end
            end
            rbe_pkg::ST_FLUSH:
            begin
                if (!flush_more)
                begin
                    state_next = rbe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rbe_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and result control
    always_comb
    begin
        emit          = 1'b0;
        div_start     = 1'b0;
        coder_next    = coder_reg;
        count_next    = count_reg;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        out_blk_next  = out_blk_reg;
        out_err_next  = out_err_reg;
        case (state_reg)
            rbe_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    count_next = '0;
                end
            end
            rbe_pkg::ST_ERROR:
            begin
                if (slot_free)
                begin
                    emit          = 1'b1;
                    out_byte_next = '0;
                    out_last_next = 1'b1;
                    out_blk_next  = 1'b0;
                    out_err_next  = 1'b1;
                end
            end
            rbe_pkg::ST_RENORM:
            begin
                if (!renorm_more)
                begin
                    div_start = 1'b1;
                end
                else if (slot_free)
                begin
                    emit          = 1'b1;
                    out_byte_next = coder_reg[rbe_pkg::BYTE_W-1:0];
                    out_last_next = renorm_last;
                    out_blk_next  = 1'b0;
                    out_err_next  = 1'b0;
                    coder_next    = coder_shr;
                    count_next    = count_reg + rbe_pkg::COUNT_W'(1);
                end
            end
            rbe_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    coder_next = coder_upd;
                end
            end
            rbe_pkg::ST_FLUSH:
            begin
                if (!flush_more)
                begin
                    coder_next = rbe_pkg::STATE_INIT;
                end
                else if (slot_free)
                begin
                    emit          = 1'b1;
                    out_byte_next = coder_reg[rbe_pkg::BYTE_W-1:0];
                    out_last_next = flush_last;
                    out_blk_next  = 1'b1;
                    out_err_next  = 1'b0;
                    coder_next    = coder_shr;
                    count_next    = count_reg + rbe_pkg::COUNT_W'(1);
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rbe_pkg::ST_IDLE;
            coder_reg     <= rbe_pkg::STATE_INIT;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            coder_reg     <= coder_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_blk_reg  <= out_blk_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_err_reg, out_blk_reg};

endmodule

/* dv/rbe_result_checker.sv */
`timescale 1ns / 1ps
// rbe_result_checker: watches both stream channels of the rANS byte encoder,
// predicts the coded bytes of every accepted request and compares them in order.
// Depends on rbe_pkg only; instantiated by tb_top beside the block.
module rbe_result_checker
    import rbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    localparam int RENORM_SHIFT = 32 - SCALE_BITS_DEF;
    localparam logic [63:0] STATE_MASK = (64'd1 << STATE_W) - 64'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              blk;
        logic              err;
    } coded_byte_t;

    logic [STATE_W-1:0] enc_state;
    logic [FREQ_W-1:0]  sym_freq [NUM_SYMBOLS_DEF];
    logic [CUM_W-1:0]   sym_cum  [NUM_SYMBOLS_DEF];
    coded_byte_t        due_bytes[$];
    int                 n_fail;
    int                 n_checked;

    task automatic encode_symbol(input logic [SYM_W-1:0] sym);
        logic [63:0] st;
        logic [63:0] fr;
        logic [63:0] lim;
        int          nb;
        st = 64'(enc_state);
        fr = 64'(sym_freq[sym]);
        nb = 0;
        if (fr == 64'd0)
        begin
            // zero frequency: one error byte, state untouched
            due_bytes.push_back('{data: '0, last: 1'b1, blk: 1'b0, err: 1'b1});
        end
        else
        begin
            lim = fr << RENORM_SHIFT;
            while (st >= lim && nb < MAX_BYTES)
            begin
                due_bytes.push_back('{data: st[7:0], last: 1'b0, blk: 1'b0, err: 1'b0});
                st = st >> 8;
                nb++;
            end
            st = (((st / fr) << SCALE_BITS_DEF) + (st % fr) + 64'(sym_cum[sym])) & STATE_MASK;
            enc_state = st[STATE_W-1:0];
            if (nb > 0)
                due_bytes[due_bytes.size()-1].last = 1'b1;
        end
    endtask

    task automatic flush_state();
        logic [63:0] st;
        int          nb;
        st = 64'(enc_state);
        nb = 0;
        while (st != 64'd0 && nb < MAX_BYTES)
        begin
            due_bytes.push_back('{data: st[7:0], last: 1'b0, blk: 1'b1, err: 1'b0});
            st = st >> 8;
            nb++;
        end
        enc_state = STATE_INIT;
        if (nb > 0)
            due_bytes[due_bytes.size()-1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        coded_byte_t want;
        op_t         op;
        if (!rst_n)
        begin
            enc_state = STATE_INIT;
            for (int i = 0; i < NUM_SYMBOLS_DEF; i++)
            begin
                sym_freq[i] = '0;
                sym_cum[i]  = '0;
            end
            due_bytes.delete();
            n_fail    = 0;
            n_checked = 0;
        end
        else
        begin
            // results first: a byte leaving now belongs to an earlier request
            if (m_tvalid && m_tready)
            begin
                if (due_bytes.size() == 0)
                begin
                    if (n_fail < 10)
                        $display("%0t: unexpected result byte=%02h last=%b user=%b",
                                 $realtime, m_tdata, m_tlast, m_tuser);
                    n_fail++;
                end
                else
                begin
                    want = due_bytes.pop_front();
                    n_checked++;
                    if (m_tdata !== want.data || m_tlast !== want.last ||
                        m_tuser[0] !== want.blk || m_tuser[1] !== want.err)
                    begin
                        if (n_fail < 10)
                            $display("%0t: mismatch byte/last/blk/err exp %02h/%b/%b/%b got %02h/%b/%b/%b",
                                     $realtime, want.data, want.last, want.blk, want.err,
                                     m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
                        n_fail++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                op = op_t'(s_tuser);
                case (op)
                    OP_LOAD:
                    begin
                        sym_freq[s_tdata[7:0]] = s_tdata[20:8];
                        sym_cum[s_tdata[7:0]]  = s_tdata[32:21];
                    end
                    OP_ENCODE: encode_symbol(s_tdata[7:0]);
                    OP_FLUSH:  flush_state();
                    default:   ;
                endcase
            end
        end
        fail_count <= n_fail;
        pending    <= due_bytes.size();
        checked    <= n_checked;
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: drives load, encode and flush requests into rans_byte_encoder_unit
// under random bursts and output stalls; rbe_result_checker judges the results.
module tb_top;

    import rbe_pkg::*;

    localparam int RANDOM_ITEMS = 250;
    localparam int IDLE_LIMIT   = 4000;  // cycles with no transfer on either side
    localparam int DRAIN_CYCLES = 80;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    int fail_count;
    int pending;
    int checked;

    int n_load;
    int n_encode;
    int n_flush;
    int n_ignored;
    int burst_left;
    int idle_cycles;

    logic [7:0] stall_cnt  = '0;
    logic [1:0] stall_mode = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rans_byte_encoder_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    rbe_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // Output side: a new stall mode is drawn whenever stall_cnt[5:0] is zero -
    // always ready, coin toss, mostly stalled, or a fixed long-stall pattern.
    always @(posedge clk)
    begin
        stall_cnt <= stall_cnt + 8'd1;
        if (stall_cnt[5:0] == 6'd0)
            stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_cnt[3:0] < 4'd5);
        endcase
    end

    // Watchdog: ends the run if the block stops moving data.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles, %0d bytes still due",
                     idle_cycles, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One request on the slave side. Called at a rising edge; returns at the edge
    // where it was taken or, when a burst of random length ends, after a gap.
    task automatic send_req(input op_t op, input logic [7:0] sym,
                            input logic [12:0] freq, input logic [11:0] cum);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, cum, freq, sym};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        case (op)
            OP_LOAD:   n_load++;
            OP_ENCODE: n_encode++;
            OP_FLUSH:  n_flush++;
            default:   n_ignored++;
        endcase
        burst_left--;
        if (burst_left <= 0)
        begin
            // occasionally a long gapless burst
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        int          n_sent;
        int          n_syms;
        int          n_codes;
        int          pick;
        logic [7:0]  sym;
        logic [12:0] freq;
        logic [7:0]  loaded[$];

        n_load     = 0;
        n_encode   = 0;
        n_flush    = 0;
        n_ignored  = 0;
        burst_left = 4;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every request code and the special cases
        send_req(OP_LOAD,   8'd0,   13'd4096,   12'd0);      // full-scale frequency
        send_req(OP_LOAD,   8'd255, 13'd1,      12'd4095);   // smallest frequency, top start
        send_req(OP_LOAD,   8'hAA,  13'd4095,   12'hAAA);
        send_req(OP_LOAD,   8'h55,  13'h0AAA,   12'h555);
        send_req(OP_LOAD,   8'd1,   13'd0,      12'd4095);   // loaded with zero frequency
        send_req(OP_ENCODE, 8'd7,   13'd0,      12'd0);      // never loaded: error
        send_req(OP_ENCODE, 8'd1,   13'd0,      12'd0);      // zero frequency: error
        send_req(OP_ENCODE, 8'd255, 13'd0,      12'd0);      // two renorm bytes
        send_req(OP_ENCODE, 8'd0,   13'd0,      12'd0);      // no renorm, no result
        send_req(OP_ENCODE, 8'hAA,  13'd0,      12'd0);
        send_req(OP_ENCODE, 8'h55,  13'd0,      12'd0);
        send_req(OP_NONE,   8'hFF,  13'h1FFF,   12'hFFF);    // ignored code
        send_req(OP_FLUSH,  8'd0,   13'd0,      12'd0);
        send_req(OP_FLUSH,  8'd0,   13'd0,      12'd0);      // initial state: five bytes
        send_req(OP_ENCODE, 8'd255, 13'd0,      12'd0);
        send_req(OP_ENCODE, 8'd255, 13'd0,      12'd0);
        send_req(OP_FLUSH,  8'hFF,  13'h1FFF,   12'hFFF);    // unused fields all ones
        send_req(OP_LOAD,   8'd255, 13'd0,      12'd0);      // overwrite with zero
        send_req(OP_ENCODE, 8'd255, 13'd0,      12'd0);

        // Random: blocks of table loads, an encode run over the loaded
        // symbols, then a flush; some runs are broken or carry noise.
        n_sent = 0;
        while (n_sent < RANDOM_ITEMS)
        begin
            loaded.delete();
            n_syms = $urandom_range(2, 10);
            for (int i = 0; i < n_syms; i++)
            begin
                sym  = 8'($urandom_range(0, 255));
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    freq = 13'd0;
                else if (pick < 3)
                    freq = 13'($urandom_range(1, 8));
                else if (pick < 6)
                    freq = 13'($urandom_range(1, 256));
                else if (pick < 9)
                    freq = 13'($urandom_range(1, 4096));
                else
                    freq = 13'd4096;
                send_req(OP_LOAD, sym, freq, 12'($urandom_range(0, 4095)));
                loaded.push_back(sym);
                n_sent++;
            end
            n_codes = $urandom_range(3, 25);
            for (int i = 0; i < n_codes; i++)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 17)
                begin
                    send_req(OP_ENCODE, loaded[$urandom_range(0, loaded.size() - 1)],
                             13'($urandom), 12'($urandom));
                    n_sent++;
                end
                else if (pick < 19)
                begin
                    send_req(OP_ENCODE, 8'($urandom_range(0, 255)),
                             13'($urandom), 12'($urandom));
                    n_sent++;
                end
                else
                    send_req(OP_NONE, 8'($urandom), 13'($urandom), 12'($urandom));
            end
            // now and then the block is left open and the next run carries on
            if ($urandom_range(0, 7) != 0)
            begin
                send_req(OP_FLUSH, 8'($urandom), 13'($urandom), 12'($urandom));
                n_sent++;
            end
        end
        send_req(OP_FLUSH, 8'd0, 13'd0, 12'd0);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d loads, %0d encodes, %0d flushes, %0d ignored requests;",
                 n_load, n_encode, n_flush, n_ignored);
        $display("%0d result bytes compared, %0d failures", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* rans_byte_encoder_unit.f */
sv/rbe_pkg.sv
sv/rbe_table.sv
sv/rbe_divider.sv
sv/rans_byte_encoder_unit.sv
dv/rbe_result_checker.sv
dv/tb_top.sv
